FILE: hdl/ta2i_pkg.sv
// ----------------------------------------------------------------------------
// ta2i_pkg
// Shared types, constants and the arctangent ROM for the interpolated atan2.
// ----------------------------------------------------------------------------
package ta2i_pkg;

    localparam int ANGLE_W     = 19;        // Q3.16 signed result
    localparam int Z_W         = 17;        // ratio, 1.0 held as 65536
    localparam int FRAC_W      = 16;
    localparam int CFG_W       = 16;
    localparam int ROM_LAST    = 256;
    localparam int ROM_ENTRIES = ROM_LAST + 1;
    localparam int ROM_IW      = 9;         // index bits for 257 entries
    localparam int ROM_DW      = 16;        // entries are Q0.16
    localparam int HALF_POS    = 32768;     // half a table step
    localparam int Z_ONE       = 65536;

    localparam logic [CFG_W-1:0] THRESH_RESET = 16'd257;

    localparam logic signed [ANGLE_W-1:0] ANGLE_PI      = 19'sd205887;
    localparam logic signed [ANGLE_W-1:0] ANGLE_HALF_PI = 19'sd102944;

    localparam longint unsigned NANO_SCALE = 64'd1000000000;
    localparam longint unsigned NANO_HALF  = 64'd500000000;

    // octant sideband carried alongside the ratio
    typedef struct packed {
        logic zero;     // both inputs zero
        logic xneg;
        logic yneg;
        logic x_major;  // |x| > |y|
    } t_oct;

    typedef logic [ROM_DW-1:0] t_rom [ROM_ENTRIES];

    // atan(i/255) for i up to 255, entry 256 repeating entry 255; units of 1e-9 rad
    localparam int unsigned ATAN_NANO [ROM_ENTRIES] = '{
        0, 3921549, 7842976, 11764160,
        15684990, 19605330, 23525070, 27444090,
        31362260, 35279470, 39195600, 43110530,
        47024130, 50936290, 54846900, 58755820,
        62662950, 66568160, 70471340, 74372380,
        78271140, 82167520, 86061410, 89952670,
        93841210, 97726910, 101609600, 105489300,
        109365800, 113239000, 117108700, 120975000,
        124837600, 128696500, 132551500, 136402600,
        140249600, 144092400, 147931000, 151765200,
        155594800, 159419900, 163240300, 167055900,
        170866500, 174672200, 178472800, 182268100,
        186058200, 189842800, 193622000, 197395600,
        201163400, 204925500, 208681800, 212432000,
        216176200, 219914300, 223646100, 227371600,
        231090700, 234803300, 238509300, 242208600,
        245901200, 249586900, 253265800, 256937600,
        260602400, 264260000, 267910400, 271553500,
        275189200, 278817500, 282438300, 286051400,
        289656900, 293254700, 296844700, 300426800,
        304000900, 307567100, 311125200, 314675200,
        318217000, 321750600, 325275800, 328792700,
        332301200, 335801200, 339292600, 342775500,
        346249700, 349715300, 353172100, 356620100,
        360059300, 363489600, 366911000, 370323400,
        373726800, 377121100, 380506400, 383882500,
        387249400, 390607000, 393955500, 397294600,
        400624400, 403944800, 407255800, 410557400,
        413849600, 417132200, 420405400, 423668900,
        426922900, 430167300, 433402100, 436627200,
        439842600, 443048300, 446244300, 449430600,
        452607000, 455773800, 458930700, 462077800,
        465215000, 468342400, 471460000, 474567600,
        477665400, 480753200, 483831200, 486899200,
        489957300, 493005500, 496043700, 499071900,
        502090200, 505098500, 508096800, 511085200,
        514063600, 517032000, 519990400, 522938800,
        525877200, 528805600, 531724100, 534632500,
        537531000, 540419500, 543298000, 546166600,
        549025100, 551873800, 554712400, 557541100,
        560359900, 563168700, 565967600, 568756600,
        571535700, 574304800, 577064100, 579813500,
        582553100, 585282800, 588002600, 590712600,
        593412800, 596103200, 598783900, 601454700,
        604115800, 606767200, 609408800, 612040700,
        614663000, 617275500, 619878400, 622471700,
        625055400, 627629400, 630193900, 632748800,
        635294200, 637830100, 640356500, 642873400,
        645380800, 647878800, 650367400, 652846600,
        655316500, 657777000, 660228200, 662670100,
        665102700, 667526100, 669940200, 672345200,
        674740900, 677127600, 679505100, 681873500,
        684232800, 686583100, 688924400, 691256700,
        693580000, 695894300, 698199800, 700496400,
        702784100, 705063000, 707333000, 709594300,
        711846900, 714090700, 716325800, 718552300,
        720770100, 722979400, 725180000, 727372100,
        729555700, 731730700, 733897400, 736055500,
        738205300, 740346700, 742479700, 744604500,
        746720900, 748829100, 750929100, 753020800,
        755104400, 757179800, 759247200, 761306400,
        763357600, 765400800, 767436000, 769463300,
        771482600, 773494000, 775497500, 777493200,
        779481100, 781461200, 783433500, 785398300,
        785398300
    };

    // Q0.16, rounded to nearest; evaluated at elaboration
    function automatic t_rom build_atan_rom();
        t_rom              r;
        longint unsigned   n;
        for (int i = 0; i < ROM_ENTRIES; i++) begin
            n    = longint'(ATAN_NANO[i]);
            r[i] = ROM_DW'((n * 64'd65536 + NANO_HALF) / NANO_SCALE);
        end
        return r;
    endfunction

    localparam t_rom ATAN_ROM = build_atan_rom();

endpackage

FILE: hdl/ta2i_prep.sv
// ----------------------------------------------------------------------------
// ta2i_prep
// Sign split, magnitudes and major/minor axis selection; one register stage.
// ----------------------------------------------------------------------------
module ta2i_prep import ta2i_pkg::*; #(
    parameter int INPUT_BITS = 24
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_adv,
    input  logic                  i_valid,
    input  logic [INPUT_BITS-1:0] i_y,
    input  logic [INPUT_BITS-1:0] i_x,
    output logic                  o_valid,
    output logic [INPUT_BITS-1:0] o_small,
    output logic [INPUT_BITS-1:0] o_large,
    output t_oct                  o_oct
);

    logic [INPUT_BITS-1:0] w_ymag;
    logic [INPUT_BITS-1:0] w_xmag;
    logic                  w_yneg;
    logic                  w_xneg;
    logic                  r_valid;
    logic [INPUT_BITS-1:0] r_small;
    logic [INPUT_BITS-1:0] r_large;
    t_oct                  r_oct;

    // most negative input maps to 2^(N-1), which still fits unsigned
    assign w_yneg = i_y[INPUT_BITS-1];
    assign w_xneg = i_x[INPUT_BITS-1];
    assign w_ymag = w_yneg ? (~i_y + INPUT_BITS'(1)) : i_y;
    assign w_xmag = w_xneg ? (~i_x + INPUT_BITS'(1)) : i_x;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_small         <= (w_ymag < w_xmag) ? w_ymag : w_xmag;
            r_large         <= (w_ymag < w_xmag) ? w_xmag : w_ymag;
            r_oct.zero      <= (w_ymag == '0) && (w_xmag == '0);
            r_oct.xneg      <= w_xneg;
            r_oct.yneg      <= w_yneg;
            r_oct.x_major   <= w_xmag > w_ymag;
        end
    end

    assign o_valid = r_valid;
    assign o_small = r_small;
    assign o_large = r_large;
    assign o_oct   = r_oct;

endmodule

FILE: hdl/ta2i_div.sv
// ----------------------------------------------------------------------------
// ta2i_div
// Pipelined restoring divider: z = floor(small * 2^16 / large), one quotient
// bit per stage, 17 stages.
// ----------------------------------------------------------------------------
module ta2i_div import ta2i_pkg::*; #(
    parameter int INPUT_BITS = 24
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_adv,
    input  logic                  i_valid,
    input  logic [INPUT_BITS-1:0] i_small,
    input  logic [INPUT_BITS-1:0] i_large,
    input  t_oct                  i_oct,
    output logic                  o_valid,
    output logic [Z_W-1:0]        o_z,
    output t_oct                  o_oct
);

    localparam int RW = INPUT_BITS + 1;   // remainder < large, doubled fits

    logic                  r_v     [Z_W];
    logic [Z_W-1:0]        r_q     [Z_W];
    t_oct                  r_oct   [Z_W];
    logic [RW-1:0]         r_rem   [Z_W-1];
    logic [INPUT_BITS-1:0] r_large [Z_W-1];

    for (genvar k = 0; k < Z_W; k++) begin : g_stage
        logic                  w_vin;
        logic [Z_W-1:0]        w_qin;
        t_oct                  w_oin;
        logic [INPUT_BITS-1:0] w_lin;
        logic [RW-1:0]         w_trial;
        logic                  w_bit;

        if (k == 0) begin : g_first
            // small <= large, so the top quotient bit is set only when equal
            assign w_vin   = i_valid;
            assign w_qin   = '0;
            assign w_oin   = i_oct;
            assign w_lin   = i_large;
            assign w_trial = RW'(i_small);
        end else begin : g_next
            assign w_vin   = r_v[k-1];
            assign w_qin   = r_q[k-1];
            assign w_oin   = r_oct[k-1];
            assign w_lin   = r_large[k-1];
            assign w_trial = {r_rem[k-1][RW-2:0], 1'b0};
        end

        assign w_bit = w_trial >= RW'(w_lin);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_adv) begin
                r_v[k] <= w_vin;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_q[k]   <= {w_qin[Z_W-2:0], w_bit};
                r_oct[k] <= w_oin;
            end
        end

        if (k < Z_W - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_adv) begin
                    r_rem[k]   <= w_bit ? (w_trial - RW'(w_lin)) : w_trial;
                    r_large[k] <= w_lin;
                end
            end
        end
    end

    assign o_valid = r_v[Z_W-1];
    assign o_z     = r_q[Z_W-1];
    assign o_oct   = r_oct[Z_W-1];

endmodule

FILE: hdl/ta2i_interp.sv
// ----------------------------------------------------------------------------
// ta2i_interp
// Base angle from the ratio: table position, ROM lookup and linear
// interpolation over four register stages; sub-threshold ratios skip the table.
// ----------------------------------------------------------------------------
module ta2i_interp import ta2i_pkg::*; #(
    parameter int TABLE_SIZE = 256
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_adv,
    input  logic [CFG_W-1:0] i_thresh,
    input  logic             i_valid,
    input  logic [Z_W-1:0]   i_z,
    input  t_oct             i_oct,
    output logic             o_valid,
    output logic [Z_W-1:0]   o_base,
    output t_oct             o_oct
);

    localparam int TSW = $clog2(TABLE_SIZE + 1);
    localparam int PRW = Z_W + TSW;      // z * TABLE_SIZE
    localparam int NST = 4;

    logic             r_v   [NST];
    t_oct             r_oct [NST];

    // stage A: position
    logic [PRW-1:0]   w_prod;
    logic [PRW-1:0]   r_a_pos;
    logic             r_a_neg;
    logic             r_a_small;
    logic [Z_W-1:0]   r_a_z;

    // stage B: lookup
    logic [ROM_IW-1:0] w_idx;
    logic [ROM_IW-1:0] w_idx_n;
    logic              w_over;
    logic [Z_W-1:0]    w_lo;
    logic [ROM_DW-1:0] w_diff;
    logic [FRAC_W-1:0] w_frac;
    logic [Z_W-1:0]    r_b_lo;
    logic [ROM_DW-1:0] r_b_diff;
    logic [FRAC_W-1:0] r_b_frac;

    // stage C: slope times fraction
    logic [2*ROM_DW-1:0] w_mul;
    logic [Z_W-1:0]      r_c_lo;
    logic [ROM_DW-1:0]   r_c_add;

    // stage D: sum
    logic [Z_W-1:0]      r_d_base;

    assign w_prod = PRW'(i_z) * PRW'(TABLE_SIZE);

    always_comb begin
        w_idx   = {1'b0, r_a_pos[FRAC_W +: ROM_IW-1]};
        w_idx_n = w_idx + ROM_IW'(1);
        w_over  = 32'(r_a_pos[PRW-1:FRAC_W]) >= ROM_LAST;
        w_diff  = '0;
        w_frac  = '0;
        if (r_a_small) begin
            w_lo = r_a_z;
        end else if (r_a_neg) begin
            w_lo = Z_W'(ATAN_ROM[0]);
        end else if (w_over) begin
            w_lo = Z_W'(ATAN_ROM[ROM_LAST]);
        end else begin
            w_lo   = Z_W'(ATAN_ROM[w_idx]);
            w_diff = ATAN_ROM[w_idx_n] - ATAN_ROM[w_idx];   // table is monotonic
            w_frac = r_a_pos[FRAC_W-1:0];
        end
    end

    assign w_mul = (2*ROM_DW)'(r_b_diff) * (2*ROM_DW)'(r_b_frac);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NST; s++) begin
                r_v[s] <= 1'b0;
            end
        end else if (i_adv) begin
            r_v[0] <= i_valid;
            for (int s = 1; s < NST; s++) begin
                r_v[s] <= r_v[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_oct[0] <= i_oct;
            for (int s = 1; s < NST; s++) begin
                r_oct[s] <= r_oct[s-1];
            end

            r_a_small <= i_z < Z_W'(i_thresh);
            r_a_neg   <= w_prod < PRW'(HALF_POS);
            r_a_pos   <= w_prod - PRW'(HALF_POS);
            r_a_z     <= i_z;

            r_b_lo    <= w_lo;
            r_b_diff  <= w_diff;
            r_b_frac  <= w_frac;

            r_c_lo    <= r_b_lo;
            r_c_add   <= w_mul[2*ROM_DW-1:FRAC_W];

            r_d_base  <= r_c_lo + Z_W'(r_c_add);
        end
    end

    assign o_valid = r_v[NST-1];
    assign o_base  = r_d_base;
    assign o_oct   = r_oct[NST-1];

endmodule

FILE: hdl/table_atan2_interpolated.sv
// ----------------------------------------------------------------------------
// table_atan2_interpolated
// atan2(y, x) in Q3.16 radians from a 257-entry arctangent ROM with linear
// interpolation, fully pipelined.
//
//   channel   direction  handshake              payload
//   in        sink       i_in_valid/o_in_stall  i_y_coord, i_x_coord
//   out       source     o_out_valid/i_out_stall o_angle
//   cfg       sink       i_cfg_valid/o_cfg_ready i_cfg_data (threshold)
//
// One beat per cycle in and out while the output is not stalled. Stages: input
// stage, 17 divider stages (one quotient bit each), 4 interpolation stages,
// output register. The divider sets the depth.
// Reset clears all valid bits and loads the threshold with 257.
// A stalled output freezes the whole pipe; o_in_stall is high exactly then.
// ----------------------------------------------------------------------------
module table_atan2_interpolated import ta2i_pkg::*; #(
    parameter int TABLE_SIZE = 256,
    parameter int INPUT_BITS = 24
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic signed [INPUT_BITS-1:0] i_y_coord,
    input  logic signed [INPUT_BITS-1:0] i_x_coord,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic signed [ANGLE_W-1:0] o_angle,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CFG_W-1:0]          i_cfg_data
);

    logic                  w_adv;
    logic [CFG_W-1:0]      r_thresh;

    logic                  w_p_valid;
    logic [INPUT_BITS-1:0] w_p_small;
    logic [INPUT_BITS-1:0] w_p_large;
    t_oct                  w_p_oct;

    logic                  w_d_valid;
    logic [Z_W-1:0]        w_d_z;
    t_oct                  w_d_oct;

    logic                  w_b_valid;
    logic [Z_W-1:0]        w_b_base;
    t_oct                  w_b_oct;

    logic signed [ANGLE_W-1:0] w_base;
    logic signed [ANGLE_W-1:0] n_angle;
    logic signed [ANGLE_W-1:0] r_angle;
    logic                      r_out_valid;

    assign w_adv       = !r_out_valid || !i_out_stall;
    assign o_in_stall  = !w_adv;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= THRESH_RESET;
        end else if (i_cfg_valid) begin
            r_thresh <= i_cfg_data;
        end
    end

    ta2i_prep #(
        .INPUT_BITS (INPUT_BITS)
    ) u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (i_in_valid),
        .i_y     (i_y_coord),
        .i_x     (i_x_coord),
        .o_valid (w_p_valid),
        .o_small (w_p_small),
        .o_large (w_p_large),
        .o_oct   (w_p_oct)
    );

    ta2i_div #(
        .INPUT_BITS (INPUT_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (w_p_valid),
        .i_small (w_p_small),
        .i_large (w_p_large),
        .i_oct   (w_p_oct),
        .o_valid (w_d_valid),
        .o_z     (w_d_z),
        .o_oct   (w_d_oct)
    );

    ta2i_interp #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_interp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (w_adv),
        .i_thresh (r_thresh),
        .i_valid  (w_d_valid),
        .i_z      (w_d_z),
        .i_oct    (w_d_oct),
        .o_valid  (w_b_valid),
        .o_base   (w_b_base),
        .o_oct    (w_b_oct)
    );

    // octant fold into [-pi, pi]
    assign w_base = signed'(ANGLE_W'(w_b_base));

    always_comb begin
        if (w_b_oct.zero) begin
            n_angle = '0;
        end else if (w_b_oct.x_major) begin
            if (!w_b_oct.xneg) begin
                n_angle = w_b_oct.yneg ? -w_base : w_base;
            end else begin
                n_angle = w_b_oct.yneg ? (w_base - ANGLE_PI) : (ANGLE_PI - w_base);
            end
        end else if (!w_b_oct.yneg) begin
            n_angle = w_b_oct.xneg ? (ANGLE_HALF_PI + w_base) : (ANGLE_HALF_PI - w_base);
        end else begin
            n_angle = w_b_oct.xneg ? (-ANGLE_HALF_PI - w_base) : (w_base - ANGLE_HALF_PI);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_angle <= n_angle;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_angle     = r_angle;

    // ratio never exceeds 1.0; a zero vector divides by zero and is folded away
    a_ratio_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_d_valid && !w_d_oct.zero) |-> (w_d_z <= Z_W'(Z_ONE)))
        else $error("divider ratio above one");

    // folded angle stays within [-pi, pi]
    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_angle <= ANGLE_PI) && (o_angle >= -ANGLE_PI)))
        else $error("angle outside +/- pi");

    // a zero vector leaves as a zero angle
    a_zero_vector: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && w_b_valid && w_b_oct.zero) |=> (o_out_valid && (o_angle == '0)))
        else $error("zero vector gave non-zero angle");

endmodule

FILE: test/table_atan2_interpolated_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// table_atan2_interpolated_tb
// Drives (y, x) coordinate beats through the interpolated atan2 block,
// predicts each angle with a table-based arctangent of its own and checks
// results in order. Runs several ratio-threshold settings and idling mixes,
// including a long output hold that backs the pipe up to the input.
// ----------------------------------------------------------------------------
module table_atan2_interpolated_tb import ta2i_pkg::*;;

    localparam int COORD_W    = 24;
    localparam int STEPS      = 256;
    localparam int LAST_ENTRY = 256;
    localparam longint PI_Q16      = 205887;
    localparam longint HALF_PI_Q16 = 102944;
    localparam int LONG_HOLD  = 300;
    localparam int SETTLE     = 30;

    typedef struct packed {
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
    } t_coord_pair;

    // atan(i/255) for i up to 255, last entry repeated, nanoradians
    localparam int unsigned ATAN_NRAD [LAST_ENTRY+1] = '{
        0, 3921549, 7842976, 11764160,
        15684990, 19605330, 23525070, 27444090,
        31362260, 35279470, 39195600, 43110530,
        47024130, 50936290, 54846900, 58755820,
        62662950, 66568160, 70471340, 74372380,
        78271140, 82167520, 86061410, 89952670,
        93841210, 97726910, 101609600, 105489300,
        109365800, 113239000, 117108700, 120975000,
        124837600, 128696500, 132551500, 136402600,
        140249600, 144092400, 147931000, 151765200,
        155594800, 159419900, 163240300, 167055900,
        170866500, 174672200, 178472800, 182268100,
        186058200, 189842800, 193622000, 197395600,
        201163400, 204925500, 208681800, 212432000,
        216176200, 219914300, 223646100, 227371600,
        231090700, 234803300, 238509300, 242208600,
        245901200, 249586900, 253265800, 256937600,
        260602400, 264260000, 267910400, 271553500,
        275189200, 278817500, 282438300, 286051400,
        289656900, 293254700, 296844700, 300426800,
        304000900, 307567100, 311125200, 314675200,
        318217000, 321750600, 325275800, 328792700,
        332301200, 335801200, 339292600, 342775500,
        346249700, 349715300, 353172100, 356620100,
        360059300, 363489600, 366911000, 370323400,
        373726800, 377121100, 380506400, 383882500,
        387249400, 390607000, 393955500, 397294600,
        400624400, 403944800, 407255800, 410557400,
        413849600, 417132200, 420405400, 423668900,
        426922900, 430167300, 433402100, 436627200,
        439842600, 443048300, 446244300, 449430600,
        452607000, 455773800, 458930700, 462077800,
        465215000, 468342400, 471460000, 474567600,
        477665400, 480753200, 483831200, 486899200,
        489957300, 493005500, 496043700, 499071900,
        502090200, 505098500, 508096800, 511085200,
        514063600, 517032000, 519990400, 522938800,
        525877200, 528805600, 531724100, 534632500,
        537531000, 540419500, 543298000, 546166600,
        549025100, 551873800, 554712400, 557541100,
        560359900, 563168700, 565967600, 568756600,
        571535700, 574304800, 577064100, 579813500,
        582553100, 585282800, 588002600, 590712600,
        593412800, 596103200, 598783900, 601454700,
        604115800, 606767200, 609408800, 612040700,
        614663000, 617275500, 619878400, 622471700,
        625055400, 627629400, 630193900, 632748800,
        635294200, 637830100, 640356500, 642873400,
        645380800, 647878800, 650367400, 652846600,
        655316500, 657777000, 660228200, 662670100,
        665102700, 667526100, 669940200, 672345200,
        674740900, 677127600, 679505100, 681873500,
        684232800, 686583100, 688924400, 691256700,
        693580000, 695894300, 698199800, 700496400,
        702784100, 705063000, 707333000, 709594300,
        711846900, 714090700, 716325800, 718552300,
        720770100, 722979400, 725180000, 727372100,
        729555700, 731730700, 733897400, 736055500,
        738205300, 740346700, 742479700, 744604500,
        746720900, 748829100, 750929100, 753020800,
        755104400, 757179800, 759247200, 761306400,
        763357600, 765400800, 767436000, 769463300,
        771482600, 773494000, 775497500, 777493200,
        779481100, 781461200, 783433500, 785398300,
        785398300
    };

    logic                      i_clk       = 1'b0;
    logic                      i_rst_n     = 1'b0;
    logic                      i_in_valid  = 1'b0;
    logic                      o_in_stall;
    logic signed [COORD_W-1:0] i_y_coord   = '0;
    logic signed [COORD_W-1:0] i_x_coord   = '0;
    logic                      o_out_valid;
    logic                      i_out_stall = 1'b0;
    logic signed [ANGLE_W-1:0] o_angle;
    logic                      i_cfg_valid = 1'b0;
    logic                      o_cfg_ready;
    logic [CFG_W-1:0]          i_cfg_data  = '0;

    t_coord_pair               pending_pairs [$];
    logic signed [ANGLE_W-1:0] angle_due [$];
    logic [CFG_W-1:0]          ratio_thresh   = 16'd257;
    int                        send_idle_pct  = 0;
    int                        recv_stall_pct = 0;
    bit                        want_long_hold = 1'b0;
    int                        hold_left      = 0;
    int                        errors         = 0;

    table_atan2_interpolated #(
        .TABLE_SIZE (STEPS),
        .INPUT_BITS (COORD_W)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_y_coord   (i_y_coord),
        .i_x_coord   (i_x_coord),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_angle     (o_angle),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // ROM entry rounded to Q0.16
    function automatic longint atan_q16(input int idx);
        return (longint'(ATAN_NRAD[idx]) * 65536 + 500000000) / 1000000000;
    endfunction

    function automatic logic signed [ANGLE_W-1:0] predict_angle(
        input logic signed [COORD_W-1:0] y,
        input logic signed [COORD_W-1:0] x,
        input logic [CFG_W-1:0]          thresh
    );
        longint ymag, xmag, lesser, greater, ratio, base, pos, idx, frac, lo, hi, ang;
        ymag = (y < 0) ? -longint'(y) : longint'(y);
        xmag = (x < 0) ? -longint'(x) : longint'(x);
        if (ymag == 0 && xmag == 0)
            return '0;
        lesser  = (ymag < xmag) ? ymag : xmag;
        greater = (ymag < xmag) ? xmag : ymag;
        ratio   = (lesser << 16) / greater;
        if (ratio < longint'(thresh)) begin
            base = ratio;
        end else begin
            pos = ratio * STEPS - 32768;
            if (pos < 0) begin
                base = atan_q16(0);
            end else begin
                idx = pos >> 16;
                if (idx >= LAST_ENTRY) begin
                    base = atan_q16(LAST_ENTRY);
                end else begin
                    frac = pos & 64'hFFFF;
                    lo   = atan_q16(int'(idx));
                    hi   = atan_q16(int'(idx) + 1);
                    base = lo + (((hi - lo) * frac) >>> 16);
                end
            end
        end
        if (xmag > ymag) begin
            if (x >= 0)
                ang = (y < 0) ? -base : base;
            else
                ang = (y < 0) ? base - PI_Q16 : PI_Q16 - base;
        end else if (y >= 0) begin
            ang = (x < 0) ? HALF_PI_Q16 + base : HALF_PI_Q16 - base;
        end else begin
            ang = (x < 0) ? -HALF_PI_Q16 - base : -HALF_PI_Q16 + base;
        end
        return ANGLE_W'(ang);
    endfunction

    // uniform in [-2^bits, 2^bits - 1]
    function automatic logic signed [COORD_W-1:0] rand_coord(input int bits);
        return COORD_W'($signed($urandom) >>> (31 - bits));
    endfunction

    function automatic t_coord_pair random_pair();
        t_coord_pair p;
        int          mode;
        mode = $urandom_range(0, 9);
        case (mode)
            4: begin
                p.y = rand_coord($urandom_range(0, 12));
                p.x = rand_coord(23);
            end
            5: begin
                p.x = rand_coord($urandom_range(0, 12));
                p.y = rand_coord(23);
            end
            6: begin
                // equal magnitudes, any signs
                p.y = rand_coord($urandom_range(0, 23));
                p.x = $urandom_range(0, 1) ? p.y : -p.y;
            end
            7: begin
                p.y = rand_coord($urandom_range(0, 23));
                p.x = '0;
                if ($urandom_range(0, 1))
                    p = '{y: p.x, x: p.y};
            end
            8: begin
                p.y = rand_coord(23);
                p.x = p.y + rand_coord(3);
                if ($urandom_range(0, 1))
                    p.x = -p.x;
            end
            9: begin
                p.y = rand_coord($urandom_range(0, 4));
                p.x = rand_coord($urandom_range(0, 4));
            end
            default: begin
                p.y = rand_coord(23);
                p.x = rand_coord(23);
            end
        endcase
        return p;
    endfunction

    task automatic push_pair(input logic signed [COORD_W-1:0] y,
                             input logic signed [COORD_W-1:0] x);
        pending_pairs.push_back('{y: y, x: x});
    endtask

    task automatic push_random(input int count);
        for (int n = 0; n < count; n++)
            pending_pairs.push_back(random_pair());
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_pairs.size() != 0 || i_in_valid || angle_due.size() != 0);
    endtask

    task automatic write_thresh(input logic [CFG_W-1:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid  <= 1'b0;
        ratio_thresh = value;
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    // input driver
    always @(posedge i_clk) begin : drive_coords
        t_coord_pair nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall)
                angle_due.push_back(predict_angle(i_y_coord, i_x_coord, ratio_thresh));
            if (!i_in_valid || !o_in_stall) begin
                if (pending_pairs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    nxt = pending_pairs.pop_front();
                    i_in_valid <= 1'b1;
                    i_y_coord  <= nxt.y;
                    i_x_coord  <= nxt.x;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // result checker and output back-pressure
    always @(posedge i_clk) begin : check_angles
        logic signed [ANGLE_W-1:0] want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (angle_due.size() == 0) begin
                    $display("%0t: unexpected angle beat, actual %0d", $time, o_angle);
                    errors++;
                end else begin
                    want = angle_due.pop_front();
                    if (o_angle !== want) begin
                        $display("%0t: angle mismatch, expected %0d actual %0d",
                                 $time, want, o_angle);
                        errors++;
                    end
                end
            end
            if (want_long_hold) begin
                hold_left      = LONG_HOLD;
                want_long_hold = 1'b0;
            end
            if (hold_left > 0) begin
                i_out_stall <= 1'b1;
                hold_left--;
            end else begin
                i_out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
            end
        end
    end

    initial begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed, reset threshold
        push_pair(0, 0);
        push_pair(0, 1);
        push_pair(0, -1);
        push_pair(1, 0);
        push_pair(-1, 0);
        push_pair(24'sh7FFFFF, 24'sh7FFFFF);
        push_pair(24'sh800000, 24'sh800000);
        push_pair(24'sh800000, 24'sh7FFFFF);
        push_pair(24'sh7FFFFF, 24'sh800000);
        push_pair(24'sh800000, 0);
        push_pair(0, 24'sh800000);
        push_pair(1, 24'sh7FFFFF);
        push_pair(-1, 24'sh7FFFFF);
        push_pair(1, 24'sh800000);
        push_pair(-1, 24'sh800000);
        push_pair(24'sh7FFFFF, 1);
        push_pair(24'sh800000, -1);
        push_pair(5, 7);
        push_pair(-7, 5);
        push_pair(3, -3);
        push_pair(-3, -3);
        push_pair(257, 65536);      // ratio right on the threshold
        push_pair(256, 65536);      // just under it
        push_pair(-65536, 258);
        wait_drained();

        // no small-ratio bypass: tiny ratios land on a negative table position
        write_thresh(16'd0);
        push_pair(1, 24'sh7FFFFF);
        push_pair(100, 65536);
        push_pair(-127, -65536);
        push_pair(65536, 128);
        push_pair(-129, 65536);
        push_random(120);
        wait_drained();

        write_thresh(16'hFFFF);
        set_idling(68, 0);
        push_random(100);
        wait_drained();

        // long output hold fills the pipe while the sender keeps offering
        write_thresh(16'd1000);
        set_idling(0, 68);
        want_long_hold = 1'b1;
        push_random(150);
        wait_drained();

        write_thresh(16'($urandom));
        set_idling(25, 25);
        push_random(150);
        wait_drained();

        write_thresh(16'd257);
        set_idling(0, 0);
        push_random(100);
        wait_drained();     // sender holds until every angle is back
        set_idling(25, 25);
        push_random(100);
        wait_drained();

        repeat (SETTLE) @(posedge i_clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: table_atan2_interpolated.f
hdl/ta2i_pkg.sv
hdl/ta2i_prep.sv
hdl/ta2i_div.sv
hdl/ta2i_interp.sv
hdl/table_atan2_interpolated.sv
test/table_atan2_interpolated_tb.sv
